>>> hdl/i8mm_pkg.sv
// ----------------------------------------------------------------------------
// i8mm_pkg
// Shared types and constants of the int8 matrix multiply with int32 sums.
// ----------------------------------------------------------------------------
package i8mm_pkg;

   localparam int MAX_INNER_DEFAULT   = 256;
   localparam int MAX_COLUMNS_DEFAULT = 16;

   localparam int INDEX_W        = 12;
   localparam int VALUE_W        = 8;
   localparam int PRODUCT_W      = 16;
   localparam int SUM_W          = 32;
   localparam int COLUMN_W       = 4;
   localparam int INNER_LENGTH_W = 9;
   localparam int COLUMN_COUNT_W = 5;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 9;

   localparam logic [INNER_LENGTH_W-1:0] INNER_LENGTH_RESET = 9'd256;
   localparam logic [COLUMN_COUNT_W-1:0] COLUMN_COUNT_RESET = 5'd16;

   localparam logic CMD_LOAD_WEIGHT = 1'b0;
   localparam logic CMD_STREAM      = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_INNER_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_COLUMN_COUNT = 1'b1;

   typedef struct packed {
      logic acc_en;
      logic row_end;
      logic drain_shift;
   } cell_ctrl_type;

endpackage

>>> hdl/i8mm_ram.sv
// ----------------------------------------------------------------------------
// i8mm_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module i8mm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/i8mm_cell.sv
// ----------------------------------------------------------------------------
// i8mm_cell
// One column: 8x8 product register, 32-bit wrapping accumulator and one
// stage of the result drain chain fed by the neighbouring cell.
// ----------------------------------------------------------------------------
module i8mm_cell (
   input  logic                                       clock,
   input  logic                                       reset,
   input  i8mm_pkg::cell_ctrl_type                    ctrl,
   input  logic signed [i8mm_pkg::VALUE_W-1:0]        value,
   input  logic signed [i8mm_pkg::VALUE_W-1:0]        weight,
   input  logic signed [i8mm_pkg::SUM_W-1:0]          drain_next,
   output logic signed [i8mm_pkg::SUM_W-1:0]          drain_out
);

   logic signed [i8mm_pkg::PRODUCT_W-1:0] prod_ff;
   logic signed [i8mm_pkg::PRODUCT_W-1:0] prod_in;
   logic signed [i8mm_pkg::SUM_W-1:0]     acc_ff;
   logic signed [i8mm_pkg::SUM_W-1:0]     acc_in;
   logic signed [i8mm_pkg::SUM_W-1:0]     sum;
   logic signed [i8mm_pkg::SUM_W-1:0]     drain_ff;
   logic signed [i8mm_pkg::SUM_W-1:0]     drain_in;

   assign prod_in = value * weight;
   assign sum     = acc_ff + {{(i8mm_pkg::SUM_W - i8mm_pkg::PRODUCT_W){prod_ff[i8mm_pkg::PRODUCT_W-1]}},
                              prod_ff};

   always_comb begin
      acc_in   = acc_ff;
      drain_in = drain_ff;
      if (ctrl.acc_en) begin
         acc_in = ctrl.row_end ? '0 : sum;
      end
      if (ctrl.acc_en && ctrl.row_end) begin
         drain_in = sum;
      end else if (ctrl.drain_shift) begin
         drain_in = drain_next;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      drain_ff <= drain_in;
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign drain_out = drain_ff;

endmodule

>>> hdl/int8_matrix_multiply_s32.sv
// ----------------------------------------------------------------------------
// int8_matrix_multiply_s32
// Signed 8-bit matrix multiply, C = A x B, with wrapping 32-bit column sums.
// ----------------------------------------------------------------------------
// One transaction is taken per clock, unless req_stall is raised: a weight load
// (cmd 0) or one A element (cmd 1). Weights sit in MAX_COLUMNS rounded up to a
// power of two (at least two) byte-wide RAM banks, interleaved on the flat weight
// index, so one A element reads all columns of its B row with one read of every
// bank; a row of identical column cells multiplies and accumulates, one cell per
// column. An element passes through four registers (issue, bank read, product,
// accumulate); at a row end the sums are loaded into the cells' drain chain
// instead, and the chain hands one result per cycle, while the output is not
// stalled, to the output register, so a row gives n results. An A element that
// ends a row is held off while the previous row end is still in the pipeline or
// its results are still in the chain, so the stream keeps one transaction per
// cycle only when each row end finds the chain empty; short rows and stalled
// results hold it off. A weight written by one transaction is seen by the next.
// ----------------------------------------------------------------------------
module int8_matrix_multiply_s32 #(
   parameter int MAX_INNER   = i8mm_pkg::MAX_INNER_DEFAULT,
   parameter int MAX_COLUMNS = i8mm_pkg::MAX_COLUMNS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic                                       req_cmd,
   input  logic [i8mm_pkg::INDEX_W-1:0]               req_weight_index,
   input  logic signed [i8mm_pkg::VALUE_W-1:0]        req_value,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic [i8mm_pkg::COLUMN_W-1:0]              rsp_column,
   output logic signed [i8mm_pkg::SUM_W-1:0]          rsp_sum,
   output logic                                       rsp_last,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [i8mm_pkg::CSR_INDEX_W-1:0]           csr_index,
   input  logic [i8mm_pkg::CSR_DATA_W-1:0]            csr_data
);

   localparam int STORE_DEPTH = MAX_INNER * MAX_COLUMNS;
   localparam int NB          = (MAX_COLUMNS <= 2) ? 2 : (1 << $clog2(MAX_COLUMNS));
   localparam int BANK_W      = $clog2(NB);
   localparam int BANK_DEPTH  = (STORE_DEPTH + NB - 1) / NB;
   localparam int ROW_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int BASE_W      = $clog2(STORE_DEPTH + 1);
   localparam int POS_W       = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
   localparam int KW          = ($clog2(MAX_INNER + 1) > i8mm_pkg::INNER_LENGTH_W) ?
                                $clog2(MAX_INNER + 1) : i8mm_pkg::INNER_LENGTH_W;
   localparam int NW          = ($clog2(MAX_COLUMNS + 1) > i8mm_pkg::COLUMN_COUNT_W) ?
                                $clog2(MAX_COLUMNS + 1) : i8mm_pkg::COLUMN_COUNT_W;
   localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);
   localparam int VW          = i8mm_pkg::VALUE_W;

   // configuration
   logic [i8mm_pkg::INNER_LENGTH_W-1:0] inner_length_ff;
   logic [i8mm_pkg::COLUMN_COUNT_W-1:0] column_count_ff;
   logic [KW-1:0]                       k_eff;
   logic [NW-1:0]                       n_eff;

   // issue
   logic [POS_W-1:0]        pos_ff;
   logic [POS_W-1:0]        pos_in;
   logic [POS_W-1:0]        pos_eff;
   logic [KW:0]             pos_next_wide;
   logic                    ends_row;
   logic                    busy;
   logic                    req_accept;
   logic                    rd_accept;
   logic [POS_W+NW-1:0]     base_full;

   // bank access
   logic                    s1_wr_ff;
   logic                    s1_rd_ff;
   logic                    s1_end_ff;
   logic [i8mm_pkg::INDEX_W-1:0] s1_idx_ff;
   logic signed [VW-1:0]    s1_val_ff;
   logic [BASE_W-1:0]       s1_base_ff;
   logic [BANK_W-1:0]       s1_base_lo;
   logic [31:0]             wr_flat;
   logic                    wr_in_range;
   logic [BANK_W-1:0]       wr_bank;
   logic [ROW_W-1:0]        wr_row;
   logic [NB*VW-1:0]        rd_flat;

   // product
   logic                    s2_rd_ff;
   logic                    s2_end_ff;
   logic signed [VW-1:0]    s2_val_ff;
   logic [BANK_W-1:0]       s2_base_lo_ff;
   logic [2*NB*VW-1:0]      rot_wide;

   // accumulate
   logic                    s3_rd_ff;
   logic                    s3_end_ff;
   i8mm_pkg::cell_ctrl_type cell_ctrl;

   // drain and output
   logic [CNT_W-1:0]        drain_count_ff;
   logic [COL_W-1:0]        drain_col_ff;
   logic                    drain_shift;
   logic signed [i8mm_pkg::SUM_W-1:0] drain_out [MAX_COLUMNS];
   logic                    rsp_valid_ff;
   logic [i8mm_pkg::COLUMN_W-1:0] rsp_column_ff;
   logic signed [i8mm_pkg::SUM_W-1:0] rsp_sum_ff;
   logic                    rsp_last_ff;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_length_ff <= i8mm_pkg::INNER_LENGTH_RESET;
         column_count_ff <= i8mm_pkg::COLUMN_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            i8mm_pkg::REG_INNER_LENGTH: begin
               inner_length_ff <= csr_data[i8mm_pkg::INNER_LENGTH_W-1:0];
            end
            i8mm_pkg::REG_COLUMN_COUNT: begin
               column_count_ff <= csr_data[i8mm_pkg::COLUMN_COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (inner_length_ff == '0) begin
         k_eff = KW'(1);
      end else if (KW'(inner_length_ff) > KW'(MAX_INNER)) begin
         k_eff = KW'(MAX_INNER);
      end else begin
         k_eff = KW'(inner_length_ff);
      end
      if (column_count_ff == '0) begin
         n_eff = NW'(1);
      end else if (NW'(column_count_ff) > NW'(MAX_COLUMNS)) begin
         n_eff = NW'(MAX_COLUMNS);
      end else begin
         n_eff = NW'(column_count_ff);
      end
   end

   // ----------------------------------------------------------------- issue
   assign pos_next_wide = (KW+1)'(pos_ff) + (KW+1)'(1);
   assign ends_row      = pos_next_wide >= (KW+1)'(k_eff);
   assign pos_eff       = ends_row ? POS_W'(k_eff - KW'(1)) : pos_ff;
   assign base_full     = (POS_W+NW)'(pos_eff) * (POS_W+NW)'(n_eff);

   assign busy       = (drain_count_ff != '0) || s1_end_ff || s2_end_ff || s3_end_ff;
   assign req_stall  = (req_cmd == i8mm_pkg::CMD_STREAM) && ends_row && busy;
   assign req_accept = req_valid && !req_stall;
   assign rd_accept  = req_accept && (req_cmd == i8mm_pkg::CMD_STREAM);
   assign pos_in     = ends_row ? '0 : POS_W'(pos_next_wide);

   always_ff @(posedge clock) begin
      s1_idx_ff  <= req_weight_index;
      s1_val_ff  <= req_value;
      s1_base_ff <= BASE_W'(base_full);
      if (reset) begin
         pos_ff    <= '0;
         s1_wr_ff  <= 1'b0;
         s1_rd_ff  <= 1'b0;
         s1_end_ff <= 1'b0;
      end else begin
         if (rd_accept) begin
            pos_ff <= pos_in;
         end
         s1_wr_ff  <= req_accept && (req_cmd == i8mm_pkg::CMD_LOAD_WEIGHT);
         s1_rd_ff  <= rd_accept;
         s1_end_ff <= rd_accept && ends_row;
      end
   end

   // ----------------------------------------------------------- bank access
   assign wr_flat     = 32'(s1_idx_ff);
   assign wr_in_range = wr_flat < STORE_DEPTH;
   assign wr_bank     = wr_flat[BANK_W-1:0];
   assign wr_row      = ROW_W'(wr_flat >> BANK_W);
   assign s1_base_lo  = s1_base_ff[BANK_W-1:0];

   for (genvar b = 0; b < NB; b++) begin : g_bank
      logic [ROW_W:0] rd_row_wide;
      logic           bank_we;

      assign rd_row_wide = (ROW_W+1)'(s1_base_ff >> BANK_W) +
                           (ROW_W+1)'(BANK_W'(b) < s1_base_lo);
      assign bank_we     = s1_wr_ff && wr_in_range && (wr_bank == BANK_W'(b));

      i8mm_ram #(
         .WIDTH (VW),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (bank_we),
         .wr_addr (wr_row),
         .wr_data (s1_val_ff),
         .rd_addr (rd_row_wide[ROW_W-1:0]),
         .rd_data (rd_flat[b*VW +: VW])
      );
   end

   always_ff @(posedge clock) begin
      s2_val_ff     <= s1_val_ff;
      s2_base_lo_ff <= s1_base_lo;
      if (reset) begin
         s2_rd_ff  <= 1'b0;
         s2_end_ff <= 1'b0;
      end else begin
         s2_rd_ff  <= s1_rd_ff;
         s2_end_ff <= s1_end_ff;
      end
   end

   // --------------------------------------------------------- column cells
   assign rot_wide = {rd_flat, rd_flat} >> {s2_base_lo_ff, 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_rd_ff  <= 1'b0;
         s3_end_ff <= 1'b0;
      end else begin
         s3_rd_ff  <= s2_rd_ff;
         s3_end_ff <= s2_end_ff;
      end
   end

   assign drain_shift = (drain_count_ff != '0) && (!rsp_valid_ff || !rsp_stall);

   assign cell_ctrl.acc_en      = s3_rd_ff;
   assign cell_ctrl.row_end     = s3_end_ff;
   assign cell_ctrl.drain_shift = drain_shift;

   for (genvar j = 0; j < MAX_COLUMNS; j++) begin : g_cell
      logic signed [i8mm_pkg::SUM_W-1:0] drain_next;
      logic                              col_used;
      i8mm_pkg::cell_ctrl_type           col_ctrl;

      // clear every column at a row end, accumulate only the columns in use
      assign col_used             = NW'(j) < n_eff;
      assign col_ctrl.acc_en      = cell_ctrl.acc_en && (col_used || cell_ctrl.row_end);
      assign col_ctrl.row_end     = cell_ctrl.row_end;
      assign col_ctrl.drain_shift = cell_ctrl.drain_shift;

      if (j == MAX_COLUMNS - 1) begin : g_tail
         assign drain_next = '0;
      end else begin : g_link
         assign drain_next = drain_out[j+1];
      end

      i8mm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (col_ctrl),
         .value      (s2_val_ff),
         .weight     (rot_wide[j*VW +: VW]),
         .drain_next (drain_next),
         .drain_out  (drain_out[j])
      );
   end

   // ---------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (drain_shift) begin
         rsp_column_ff <= i8mm_pkg::COLUMN_W'(drain_col_ff);
         rsp_sum_ff    <= drain_out[0];
         rsp_last_ff   <= drain_count_ff == CNT_W'(1);
      end
      if (reset) begin
         drain_count_ff <= '0;
         drain_col_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (s3_rd_ff && s3_end_ff) begin
            drain_count_ff <= CNT_W'(n_eff);
            drain_col_ff   <= '0;
         end else if (drain_shift) begin
            drain_count_ff <= drain_count_ff - CNT_W'(1);
            drain_col_ff   <= drain_col_ff + COL_W'(1);
         end
         if (drain_shift) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_column = rsp_column_ff;
   assign rsp_sum    = rsp_sum_ff;
   assign rsp_last   = rsp_last_ff;

   // ------------------------------------------------------------ assertions
   a_drain_empty_at_row_end : assert property (@(posedge clock) disable iff (reset)
      (s3_rd_ff && s3_end_ff) |-> (drain_count_ff == '0))
      else $error("row end reached the cells while the drain chain was busy");

   a_one_row_end_in_flight : assert property (@(posedge clock) disable iff (reset)
      $countones({s1_end_ff, s2_end_ff, s3_end_ff}) <= 1)
      else $error("more than one row end in flight");

   a_last_on_final_column : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_column_ff == i8mm_pkg::COLUMN_W'(n_eff - NW'(1))))
      else $error("last flag not on the final column");

   a_drain_count_bound : assert property (@(posedge clock) disable iff (reset)
      drain_count_ff <= CNT_W'(MAX_COLUMNS))
      else $error("drain count above column limit");

endmodule
